// ----- sv/css_pkg.sv -----
// ----------------------------------------------------------------------------
// css_pkg
// Types, codes and helpers shared by the segment store modules.
// ----------------------------------------------------------------------------
package css_pkg;

  localparam int unsigned StoreBytesDef = 1024;
  localparam int unsigned MaxSlotsDef   = 16;
  localparam int unsigned NameCharsDef  = 8;
  localparam logic [10:0] CapResetVal   = 11'd1024;

  localparam logic [2:0] FuncOpen   = 3'd0;
  localparam logic [2:0] FuncWrite  = 3'd1;
  localparam logic [2:0] FuncRemove = 3'd2;
  localparam logic [2:0] FuncSearch = 3'd3;
  localparam logic [2:0] FuncRead   = 3'd4;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNoSpace  = 3'd1;
  localparam logic [2:0] StFull     = 3'd2;
  localparam logic [2:0] StBadIndex = 3'd3;
  localparam logic [2:0] StNotFound = 3'd4;
  localparam logic [2:0] StNoOpen   = 3'd5;

  typedef struct packed {
    logic [2:0]  func;
    logic [10:0] entry_size;
    logic [63:0] name_key;
    logic [7:0]  data_byte;
    logic [3:0]  entry_index;
    logic [9:0]  byte_address;
  } css_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  found_index;
    logic [7:0]  read_data;
    logic [10:0] used_bytes;
    logic [4:0]  count_now;
  } css_out_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture the input item
    logic do_open;
    logic do_write;
    logic rm_start;  // latch slot being removed
    logic sh_slot;   // move one descriptor down
    logic mv_rd;     // issue byte read for slide
    logic mv_wr;     // write slid byte
    logic clr_wr;    // zero one tail byte
    logic rm_end;
    logic srch_step;
    logic rd_issue;
    logic rd_take;   // store read data is valid
    logic done;      // form result
  } css_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       open_ok_space;
    logic       open_ok_slot;
    logic       pend_nz;
    logic       idx_ok;
    logic       sh_more;   // more descriptors to move
    logic       mv_more;   // more bytes to slide
    logic       clr_more;  // more tail bytes to zero
    logic       srch_hit;
    logic       srch_more;
    logic       rd_ok;     // read address inside the store
    logic       init_done;
  } css_sts_t;

  function automatic logic [63:0] name_norm(input logic [63:0] key, input int unsigned nc);
    logic [63:0] o;
    logic stop;
    o = '0;
    stop = 1'b0;
    for (int c = 0; c < 8; c++) begin
      if (c < nc && !stop) begin
        if (key[8*c +: 8] == 8'd0) stop = 1'b1;
        else o[8*c +: 8] = key[8*c +: 8];
      end
    end
    return o;
  endfunction

endpackage

// ----- sv/css_ram.sv -----
// ----------------------------------------------------------------------------
// css_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module css_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- sv/css_datapath.sv -----
// ----------------------------------------------------------------------------
// css_datapath
// Descriptor table, byte store and counters of the segment store.
// ----------------------------------------------------------------------------
module css_datapath #(
  parameter int unsigned StoreBytes = css_pkg::StoreBytesDef,
  parameter int unsigned MaxSlots   = css_pkg::MaxSlotsDef,
  parameter int unsigned NameChars  = css_pkg::NameCharsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  css_pkg::css_in_t  in_i,
  input  logic [10:0]       cap_i,
  input  css_pkg::css_cmd_t cmd_i,
  output css_pkg::css_sts_t sts_o,
  output css_pkg::css_out_t res_o
);
  import css_pkg::*;

  localparam int unsigned AW = $clog2(StoreBytes);
  localparam int unsigned SW = $clog2(MaxSlots);
  localparam int unsigned PW = AW + 1;   // positions up to StoreBytes
  localparam int unsigned CW = SW + 1;

  css_in_t          it_q;
  logic [PW-1:0]    fill_q, pend_q, len_q, src_q, dst_q;
  logic [CW-1:0]    cnt_q, si_q;
  logic [PW-1:0]    s_start_q [MaxSlots];
  logic [PW-1:0]    s_len_q   [MaxSlots];
  logic [63:0]      s_name_q  [MaxSlots];
  logic [3:0]       fnd_q;
  logic [7:0]       rdat_q;
  logic [63:0]      want_q;
  logic [10:0]      used_w;
  css_out_t         res_q;

  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [7:0]       ram_wd, ram_rd;

  css_ram #(.Width(8), .Depth(StoreBytes)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wd), .rdata_o(ram_rd)
  );

  logic [PW:0] usable, need, wpos;
  logic [SW-1:0] si_idx;
  assign si_idx = si_q[SW-1:0];
  assign usable = ({1'b0, cap_i} > (PW+1)'(StoreBytes)) ? (PW+1)'(StoreBytes)
                : (PW+1)'(cap_i);
  assign need   = (PW+1)'(fill_q) + (PW+1)'(it_q.entry_size);
  assign wpos   = (PW+1)'(fill_q - pend_q);

  // store has an init clear pass; fill_q reused as sweep pointer is avoided
  logic          init_q;
  logic [PW-1:0] ip_q;

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = src_q[AW-1:0];
    ram_wd   = 8'd0;
    if (init_q) begin
      ram_we = 1'b1; ram_addr = ip_q[AW-1:0];
    end else if (cmd_i.do_write) begin
      ram_we = wpos < (PW+1)'(StoreBytes);
      ram_addr = wpos[AW-1:0]; ram_wd = it_q.data_byte;
    end else if (cmd_i.mv_wr) begin
      ram_we = 1'b1; ram_addr = dst_q[AW-1:0]; ram_wd = ram_rd;
    end else if (cmd_i.clr_wr) begin
      ram_we = 1'b1; ram_addr = dst_q[AW-1:0];
    end else if (cmd_i.rd_issue) begin
      ram_addr = AW'(it_q.byte_address);
    end
  end

  always_comb begin
    sts_o.func          = it_q.func;
    sts_o.open_ok_space = need <= usable;
    sts_o.open_ok_slot  = cnt_q < CW'(MaxSlots);
    sts_o.pend_nz       = pend_q != '0;
    sts_o.idx_ok        = {1'b0, it_q.entry_index} < 5'(cnt_q);
    sts_o.sh_more       = si_q + 1'b1 < cnt_q;
    sts_o.mv_more       = (PW+1)'(src_q) < (PW+1)'(fill_q)
                          && (PW+1)'(src_q) < (PW+1)'(StoreBytes);
    sts_o.clr_more      = dst_q < fill_q && (PW+1)'(dst_q) < (PW+1)'(StoreBytes);
    sts_o.srch_hit      = si_q < cnt_q && s_name_q[si_idx] == want_q;
    sts_o.srch_more     = si_q < cnt_q;
    sts_o.rd_ok         = 32'(it_q.byte_address) < 32'(StoreBytes);
    sts_o.init_done     = !init_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0; pend_q <= '0; cnt_q <= '0;
      init_q <= 1'b1; ip_q <= '0;
    end else begin
      if (init_q) begin
        ip_q <= ip_q + 1'b1;
        if (ip_q == PW'(StoreBytes - 1)) init_q <= 1'b0;
      end
      if (cmd_i.do_open) begin
        cnt_q  <= cnt_q + 1'b1;
        fill_q <= fill_q + PW'(it_q.entry_size);
        pend_q <= PW'(it_q.entry_size);
      end
      if (cmd_i.do_write) pend_q <= pend_q - 1'b1;
      if (cmd_i.rm_start) begin
        if (pend_q != '0 && 5'(it_q.entry_index) + 5'd1 == 5'(cnt_q)) pend_q <= '0;
      end
      if (cmd_i.rm_end) begin
        fill_q <= fill_q - len_q;
        cnt_q  <= cnt_q - 1'b1;
      end
    end
  end

  // descriptor table
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_open) begin
      s_start_q[cnt_q[SW-1:0]] <= fill_q;
      s_len_q[cnt_q[SW-1:0]]   <= PW'(it_q.entry_size);
      s_name_q[cnt_q[SW-1:0]]  <= name_norm(it_q.name_key, NameChars);
    end
    if (cmd_i.sh_slot) begin
      s_start_q[si_idx] <= s_start_q[SW'(si_q + 1'b1)] - len_q;
      s_len_q[si_idx]   <= s_len_q[SW'(si_q + 1'b1)];
      s_name_q[si_idx]  <= s_name_q[SW'(si_q + 1'b1)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      it_q <= in_i;
      want_q <= name_norm(in_i.name_key, NameChars);
      fnd_q <= '0; rdat_q <= '0;
    end
    if (cmd_i.rm_start) begin
      len_q <= s_len_q[it_q.entry_index[SW-1:0]];
      dst_q <= s_start_q[it_q.entry_index[SW-1:0]];
      src_q <= s_start_q[it_q.entry_index[SW-1:0]] + s_len_q[it_q.entry_index[SW-1:0]];
    end
    if (cmd_i.mv_rd)   src_q <= src_q + 1'b1;
    if (cmd_i.mv_wr || cmd_i.clr_wr) dst_q <= dst_q + 1'b1;
    // slot walk shared by remove and search
    if (cmd_i.load) si_q <= '0;
    else if (cmd_i.rm_start) si_q <= CW'(it_q.entry_index);
    else if (cmd_i.sh_slot || (cmd_i.srch_step && !sts_o.srch_hit)) si_q <= si_q + 1'b1;
    if (cmd_i.srch_step && sts_o.srch_hit) fnd_q <= 4'(si_q);
    if (cmd_i.rd_take && sts_o.rd_ok) rdat_q <= ram_rd;
    if (cmd_i.done) begin
      res_q.status      <= StOk;
      res_q.found_index <= fnd_q;
      res_q.read_data   <= rdat_q;
      res_q.used_bytes  <= used_w;
      res_q.count_now   <= 5'(cnt_q);
    end
  end

  assign used_w = 11'(fill_q);
  assign res_o  = res_q;
endmodule

// ----- sv/css_ctrl.sv -----
// ----------------------------------------------------------------------------
// css_ctrl
// Sequencer for open, write, remove, search and read items.
// ----------------------------------------------------------------------------
module css_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  css_pkg::css_sts_t sts_i,
  output css_pkg::css_cmd_t cmd_o,
  output logic [2:0]        status_o
);
  import css_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DEC, S_SHIFT, S_MVRD, S_MVWR, S_CLR, S_SRCH, S_RD, S_DONE
  } state_e;

  state_e   st_q;
  logic [2:0] stat_q;
  logic     ov_q;

  assign in_stall_o  = (st_q != S_IDLE) || ov_q;
  assign out_valid_o = ov_q;
  assign status_o    = stat_q;

  always_comb begin
    cmd_o = '0;
    case (st_q)
      S_IDLE:  cmd_o.load = in_valid_i && !ov_q;
      S_DEC: begin
        case (sts_i.func)
          FuncOpen:   cmd_o.do_open  = sts_i.open_ok_space && sts_i.open_ok_slot;
          FuncWrite:  cmd_o.do_write = sts_i.pend_nz;
          FuncRemove: cmd_o.rm_start = sts_i.idx_ok;
          FuncRead:   cmd_o.rd_issue = 1'b1;
          default: ;
        endcase
      end
      S_SHIFT: cmd_o.sh_slot = sts_i.sh_more;
      S_MVRD:  cmd_o.mv_rd   = sts_i.mv_more;
      S_MVWR:  cmd_o.mv_wr   = 1'b1;
      S_CLR: begin
        cmd_o.clr_wr = sts_i.clr_more;
        cmd_o.rm_end = !sts_i.clr_more;
      end
      S_SRCH:  cmd_o.srch_step = 1'b1;
      S_RD:    cmd_o.rd_take = 1'b1;
      S_DONE:  cmd_o.done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_INIT; stat_q <= StOk; ov_q <= 1'b0;
    end else begin
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      case (st_q)
        S_INIT: if (sts_i.init_done) st_q <= S_IDLE;
        S_IDLE: if (in_valid_i && !ov_q) st_q <= S_DEC;
        S_DEC: begin
          case (sts_i.func)
            FuncOpen: begin
              st_q <= S_DONE;
              if (!sts_i.open_ok_space) stat_q <= StNoSpace;
              else if (!sts_i.open_ok_slot) stat_q <= StFull;
              else stat_q <= StOk;
            end
            FuncWrite: begin
              st_q   <= S_DONE;
              stat_q <= sts_i.pend_nz ? StOk : StNoOpen;
            end
            FuncRemove: begin
              st_q   <= sts_i.idx_ok ? S_SHIFT : S_DONE;
              stat_q <= sts_i.idx_ok ? StOk : StBadIndex;
            end
            FuncSearch: begin
              st_q <= S_SRCH; stat_q <= StOk;
            end
            FuncRead: begin
              st_q   <= S_RD;
              stat_q <= sts_i.rd_ok ? StOk : StBadIndex;
            end
            default: begin
              st_q <= S_DONE; stat_q <= StOk;
            end
          endcase
        end
        S_SHIFT: if (!sts_i.sh_more) st_q <= S_MVRD;
        S_MVRD:  st_q <= sts_i.mv_more ? S_MVWR : S_CLR;
        S_MVWR:  st_q <= S_MVRD;
        S_CLR:   if (!sts_i.clr_more) st_q <= S_DONE;
        S_SRCH: begin
          if (sts_i.srch_hit) st_q <= S_DONE;
          else if (!sts_i.srch_more) begin
            stat_q <= StNotFound; st_q <= S_DONE;
          end
        end
        S_RD:  st_q <= S_DONE;
        S_DONE: begin
          ov_q <= 1'b1; st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- sv/compacting_segment_store.sv -----
// ----------------------------------------------------------------------------
// compacting_segment_store
// Byte store with a named-entry descriptor table and compaction on removal.
// ----------------------------------------------------------------------------
// One item is taken at a time and yields one result; the next item is taken
// once that result has been transferred. Open, write and unknown items pass
// through decode and result states, and a read adds a state for the store
// read; a search visits the table slots in turn; a removal moves the later
// descriptors down, slides the bytes above the entry down through the single
// store port, reading then writing each byte, and zeroes the tail bytes.
// After reset a clearing pass over all StoreBytes bytes zeroes the store
// before the first item is taken.
module compacting_segment_store #(
  parameter int unsigned StoreBytes = css_pkg::StoreBytesDef,
  parameter int unsigned MaxSlots   = css_pkg::MaxSlotsDef,
  parameter int unsigned NameChars  = css_pkg::NameCharsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [10:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  css_pkg::css_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output css_pkg::css_out_t out_data_o
);
  import css_pkg::*;

  logic [10:0] cap_q;
  css_cmd_t    cmd;
  css_sts_t    sts;
  css_out_t    res;
  logic [2:0]  stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= CapResetVal;
    else if (cfg_we_i) cap_q <= cfg_wdata_i;
  end

  css_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd), .status_o(stat)
  );

  css_datapath #(.StoreBytes(StoreBytes), .MaxSlots(MaxSlots), .NameChars(NameChars)) u_dp (
    .clk_i, .rst_ni, .in_i(in_data_i), .cap_i(cap_q), .cmd_i(cmd),
    .sts_o(sts), .res_o(res)
  );

  always_comb begin
    out_data_o = res;
    out_data_o.status = stat;
  end
endmodule

// ----- tb/sv/compacting_segment_store_tb.sv -----
// ----------------------------------------------------------------------------
// compacting_segment_store_tb
// Self-checking regression of the segment store: directed and random items
// are predicted by a behavioral copy of the store and every result is
// compared field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module compacting_segment_store_tb;
  import css_pkg::*;

  localparam int unsigned NBytes    = 1024;
  localparam int unsigned NSlots    = 16;
  localparam int unsigned WdogLimit = 20000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  css_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  css_out_t out_data_o;

  compacting_segment_store DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .in_data_i, .out_valid_o, .out_stall_i, .out_data_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the store
  logic [7:0]  mem_q [NBytes];
  logic [10:0] start_q [NSlots];
  logic [10:0] len_q [NSlots];
  logic [63:0] nm_q [NSlots];
  int unsigned fill_q, cnt_q, pend_q, cap_q;

  css_out_t    result_q [$];
  int unsigned errors = 0;
  int unsigned idle_cyc = 0;
  bit          quiet = 1'b0;   // no idling stretch

  function automatic logic [63:0] key_trim(input logic [63:0] k);
    logic [63:0] o;
    logic stop;
    o = '0;
    stop = 1'b0;
    for (int c = 0; c < 8; c++) begin
      if (!stop) begin
        if (k[8*c +: 8] == 8'd0) stop = 1'b1;
        else o[8*c +: 8] = k[8*c +: 8];
      end
    end
    return o;
  endfunction

  function automatic css_out_t store_predict(input css_in_t it);
    css_out_t r;
    int unsigned st, ln, lim;
    logic [63:0] want;
    r = '0;
    lim = (cap_q > NBytes) ? NBytes : cap_q;
    case (it.func)
      FuncOpen: begin
        if (fill_q + it.entry_size > lim) r.status = StNoSpace;
        else if (cnt_q >= NSlots) r.status = StFull;
        else begin
          start_q[cnt_q] = fill_q[10:0];
          len_q[cnt_q] = it.entry_size;
          nm_q[cnt_q] = key_trim(it.name_key);
          cnt_q++;
          fill_q += it.entry_size;
          pend_q = it.entry_size;
        end
      end
      FuncWrite: begin
        if (pend_q == 0) r.status = StNoOpen;
        else begin
          if (fill_q - pend_q < NBytes) mem_q[fill_q - pend_q] = it.data_byte;
          pend_q--;
        end
      end
      FuncRemove: begin
        if (it.entry_index >= cnt_q) r.status = StBadIndex;
        else begin
          st = start_q[it.entry_index];
          ln = len_q[it.entry_index];
          if (pend_q != 0 && it.entry_index + 1 == cnt_q) pend_q = 0;
          for (int unsigned i = it.entry_index; i + 1 < cnt_q; i++) begin
            start_q[i] = start_q[i+1] - ln[10:0];
            len_q[i] = len_q[i+1];
            nm_q[i] = nm_q[i+1];
          end
          for (int unsigned i = st; i + ln < fill_q && i + ln < NBytes; i++)
            mem_q[i] = mem_q[i+ln];
          for (int unsigned i = fill_q - ln; i < fill_q && i < NBytes; i++)
            mem_q[i] = 8'd0;
          fill_q -= ln;
          cnt_q--;
        end
      end
      FuncSearch: begin
        want = key_trim(it.name_key);
        r.status = StNotFound;
        for (int unsigned i = 0; i < cnt_q; i++)
          if (r.status == StNotFound && nm_q[i] == want) begin
            r.status = StOk;
            r.found_index = i[3:0];
          end
      end
      FuncRead: r.read_data = mem_q[it.byte_address];
      default: ;
    endcase
    r.used_bytes = fill_q[10:0];
    r.count_now = cnt_q[4:0];
    return r;
  endfunction

  function automatic bit idle_now();
    return !quiet && ($urandom_range(99) < 25);
  endfunction

  task automatic send_item(input css_in_t it);
    while (idle_now()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_data_i <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    result_q.push_back(store_predict(it));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(negedge clk_i);
    repeat (2 * NBytes + 50) @(negedge clk_i);
  endtask

  task automatic set_capacity(input logic [10:0] v);
    drain();
    cfg_wdata_i <= v;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cap_q = v;
  endtask

  function automatic css_in_t mk(input logic [2:0] f, input int unsigned sz,
                                 input logic [63:0] k, input logic [7:0] b,
                                 input int unsigned ix, input int unsigned ad);
    css_in_t it;
    it = '{f, sz[10:0], k, b, ix[3:0], ad[9:0]};
    return it;
  endfunction

  function automatic css_in_t noise_fill(input css_in_t it);
    css_in_t n;
    n = it;
    if (it.func != FuncOpen) n.entry_size = 11'($urandom);
    if (it.func != FuncOpen && it.func != FuncSearch) n.name_key = {$urandom, $urandom};
    if (it.func != FuncWrite) n.data_byte = 8'($urandom);
    if (it.func != FuncRemove) n.entry_index = 4'($urandom);
    if (it.func != FuncRead) n.byte_address = 10'($urandom);
    return n;
  endfunction

  task automatic test_directed();
    send_item(mk(FuncWrite, 0, 0, 8'hFF, 0, 0));              // nothing open
    send_item(mk(FuncRemove, 0, 0, 0, 15, 0));                // bad index
    send_item(mk(FuncSearch, 0, 64'h0, 0, 0, 0));             // empty table
    send_item(mk(FuncOpen, 1025, 64'h41, 0, 0, 0));           // no space
    send_item(mk(FuncOpen, 3, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0));
    send_item(mk(FuncWrite, 0, 0, 8'hFF, 0, 0));
    send_item(mk(FuncWrite, 0, 0, 8'h00, 0, 0));
    send_item(mk(FuncOpen, 0, 64'h0000_0000_0042, 0, 0, 0));  // zero length
    send_item(mk(FuncOpen, 2, 64'hAA00_4443, 0, 0, 0));       // bytes after end
    send_item(mk(FuncWrite, 0, 0, 8'h5A, 0, 0));
    send_item(mk(FuncSearch, 0, 64'h1100_4443, 0, 0, 0));
    send_item(mk(FuncRead, 0, 0, 0, 0, 1023));
    send_item(mk(FuncRead, 0, 0, 0, 0, 0));
    send_item(mk(FuncRemove, 0, 0, 0, 0, 0));                 // keeps pending
    send_item(mk(FuncWrite, 0, 0, 8'h11, 0, 0));
    send_item(mk(FuncRead, 0, 0, 0, 0, 0));
    send_item(mk(FuncOpen, 1022, 64'h45, 0, 0, 0));           // fills store
    send_item(mk(FuncWrite, 0, 0, 8'h77, 0, 0));
    send_item(mk(FuncRemove, 0, 0, 0, 0, 0));
    send_item(mk(FuncRead, 0, 0, 0, 0, 1));
    send_item(mk(3'd7, 5, 64'h1, 1, 1, 1));                   // unknown func
    send_item(mk(3'd5, 0, 0, 0, 0, 0));
    for (int i = 0; i < 17; i++)                              // table full
      send_item(mk(FuncOpen, 0, 64'(i + 1), 0, 0, 0));
  endtask

  task automatic test_random(input int unsigned n);
    css_in_t it;
    int unsigned k, p;
    k = 0;
    while (k < n) begin
      p = $urandom_range(99);
      it = noise_fill('0);
      if (p < 12 || cnt_q == 0) begin
        // well-formed entry: open and fill, at times only in part
        it.func = FuncOpen;
        it.entry_size = ($urandom_range(9) == 0) ? 11'($urandom_range(1024))
                                                  : 11'($urandom_range(12));
        it.name_key = ($urandom_range(1)) ? 64'($urandom_range(3) + 1)
                                          : {$urandom, $urandom};
        send_item(it); k++;
        p = pend_q;
        if ($urandom_range(7) == 0 && p > 1) p = $urandom_range(p - 1);
        for (int unsigned j = 0; j < p && k < n; j++) begin
          it = noise_fill('0);
          it.func = FuncWrite;
          it.data_byte = 8'($urandom);
          send_item(it); k++;
        end
      end else begin
        case ($urandom_range(5))
          0: it.func = FuncWrite;
          1: begin
            it.func = FuncRemove;
            it.entry_index = ($urandom_range(4) == 0) ? 4'($urandom)
                                                      : 4'($urandom_range(cnt_q - 1));
          end
          2: begin
            it.func = FuncSearch;
            it.name_key = ($urandom_range(1)) ? nm_q[$urandom_range(cnt_q - 1)]
                                              : 64'($urandom_range(4));
            if ($urandom_range(1)) it.name_key[63:56] = 8'($urandom);
          end
          5: it.func = 3'($urandom_range(7, 5));
          default: begin
            it.func = FuncRead;
            it.byte_address = ($urandom_range(3) == 0) ? 10'($urandom)
                                                       : 10'($urandom_range(fill_q + 2));
          end
        endcase
        send_item(it); k++;
      end
    end
  endtask

  // output side: stall at random, check each transfer
  always @(negedge clk_i) out_stall_i <= idle_now();

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (result_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %p", $realtime, out_data_o);
        errors++;
      end else begin
        if (out_data_o !== result_q[0]) begin
          $display("%0t result mismatch: expected %p, actual %p",
                   $realtime, result_q[0], out_data_o);
          errors++;
        end
        void'(result_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WdogLimit) begin
      $display("compacting_segment_store regression: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NBytes; i++) mem_q[i] = 8'd0;
    fill_q = 0; cnt_q = 0; pend_q = 0; cap_q = 1024;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    set_capacity(11'd0);
    test_random(30);
    set_capacity(11'd2047);              // above store size
    quiet = 1'b1;
    test_random(100);
    quiet = 1'b0;
    set_capacity(11'd64);
    test_random(150);
    set_capacity(11'd1024);
    test_random(280);
    drain();
    if (errors == 0) $display("compacting_segment_store regression: pass");
    else $display("compacting_segment_store regression: fail");
    $finish;
  end
endmodule

// ----- filelist.f -----
sv/css_pkg.sv
sv/css_ram.sv
sv/css_datapath.sv
sv/css_ctrl.sv
sv/compacting_segment_store.sv
tb/sv/compacting_segment_store_tb.sv
